/* src/value_stack_with_remove_at_core_assert.svh */
// ----------------------------------------------------------------------------
// value stack assertion macros
// shared property wrappers for the stack core checker
// ----------------------------------------------------------------------------
`ifndef VALUE_STACK_WITH_REMOVE_AT_CORE_ASSERT_SVH
`define VALUE_STACK_WITH_REMOVE_AT_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define VSRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack core assertion failed");

// next-cycle implication, disabled while in reset
`define VSRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack core assertion failed");

`endif

/* src/vsra_pkg.sv */
// ----------------------------------------------------------------------------
// vsra_pkg
// constants and codes shared by the value stack core and its checker
// ----------------------------------------------------------------------------
package vsra_pkg;

    // store geometry
    localparam int DEPTH   = 256;
    localparam int VALUE_W = 64;
    localparam int ADDR_W  = $clog2(DEPTH);

    // field widths
    localparam int CMD_W   = 3;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = 9;
    localparam int LVL_W   = 9;
    localparam int SLOT_W  = 8;
    localparam int ST_W    = 2;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 88;
    localparam int M_PAD_W   = M_TDATA_W - DATA_W - SLOT_W - LVL_W;

    // capacity after reset
    localparam logic [LVL_W-1:0] CAP_RESET = LVL_W'(256);

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RESERVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_MANY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_OVER  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDER = 2'd2;
    localparam logic [ST_W-1:0] ST_ZERO  = 2'd3;

endpackage

/* src/value_stack_with_remove_at_core.sv */
// ----------------------------------------------------------------------------
// value_stack_with_remove_at_core
// bounded value stack with push, reserve, pop, pop many, clear and remove at depth
// ----------------------------------------------------------------------------
// usage
//   s_* carries one command request: cmd in s_tuser, value, count and
//   from_end in s_tdata. m_* returns exactly one result per request:
//   status in m_tuser, read_value, slot_index and level in m_tdata.
//   cfg_we/cfg_wdata set the capacity register; write it only when idle.
// sequencing
//   push, reserve, clear and failed commands: request, S_DONE, output
//   register; pop and pop many: S_READ first (one registered ram read).
//   remove at depth count: S_READ, then S_SHIFT moves one element per
//   cycle through the single ram write port while the block holds
//   s_tready low. a new request is taken once the sequencer is back idle.
// reset
//   level clears to zero and capacity returns to 256; the store itself is
//   not cleared, so no clearing pass is needed.
// stall
//   a result waits in the output register while m_tready is low; one more
//   request can be taken meanwhile and finishes once the register frees.
// ----------------------------------------------------------------------------
module value_stack_with_remove_at_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vsra_pkg::LVL_W-1:0]         cfg_wdata,  // capacity
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [vsra_pkg::S_TDATA_W-1:0]     s_tdata,    // value, count, from_end, pad
    input  logic [vsra_pkg::CMD_W-1:0]         s_tuser,    // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vsra_pkg::M_TDATA_W-1:0]     m_tdata,    // read_value, slot_index, level, pad
    output logic [vsra_pkg::ST_W-1:0]          m_tuser     // status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    logic [vsra_pkg::LVL_W-1:0]       level_reg, level_next;
    logic [vsra_pkg::LVL_W-1:0]       capacity_reg;
    logic [vsra_pkg::ST_W-1:0]        status_reg, status_next;
    logic [vsra_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [vsra_pkg::VALUE_W-1:0]     rd_reg, rd_next;
    logic                             rem_reg, rem_next;
    logic [vsra_pkg::ADDR_W-1:0]      ptr_reg, ptr_next;
    logic [vsra_pkg::ADDR_W-1:0]      last_reg, last_next;
    logic                             m_valid_reg, m_valid_next;
    logic [vsra_pkg::M_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic [vsra_pkg::ST_W-1:0]        m_user_reg, m_user_next;

    // request fields
    logic [vsra_pkg::VALUE_W-1:0]     value_in;
    logic [vsra_pkg::CNT_W-1:0]       count_in;
    logic                             from_end_in;
    logic                             accept;

    // decode results
    logic [vsra_pkg::LVL_W-1:0]       lim;
    logic [vsra_pkg::ST_W-1:0]        dec_status;
    logic [vsra_pkg::LVL_W-1:0]       dec_level;
    logic [vsra_pkg::SLOT_W-1:0]      dec_slot;
    logic                             dec_read;
    logic                             dec_write;
    logic                             dec_rem;
    logic [vsra_pkg::LVL_W-1:0]       dec_raddr;

    // ram port
    logic                             ram_we;
    logic [vsra_pkg::ADDR_W-1:0]      ram_waddr;
    logic [vsra_pkg::VALUE_W-1:0]     ram_wdata;
    logic [vsra_pkg::ADDR_W-1:0]      ram_raddr;
    logic [vsra_pkg::VALUE_W-1:0]     ram_rdata;
    logic                             out_free;

    assign value_in    = s_tdata[vsra_pkg::VALUE_W-1:0];
    assign count_in    = s_tdata[vsra_pkg::DATA_W +: vsra_pkg::CNT_W];
    assign from_end_in = s_tdata[vsra_pkg::DATA_W + vsra_pkg::CNT_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // usable limit, capacity saturated at the store depth
    assign lim = (capacity_reg > vsra_pkg::LVL_W'(vsra_pkg::DEPTH))
               ? vsra_pkg::LVL_W'(vsra_pkg::DEPTH) : capacity_reg;

    // command decode against the current level
    always_comb
    begin
        dec_status = vsra_pkg::ST_OK;
        dec_level  = level_reg;
        dec_slot   = '0;
        dec_read   = 1'b0;
        dec_write  = 1'b0;
        dec_rem    = 1'b0;
        dec_raddr  = '0;
        case (s_tuser)
            vsra_pkg::CMD_PUSH:
            begin
                if (level_reg >= lim)
                begin
                    dec_status = vsra_pkg::ST_OVER;
                end
                else
                begin
                    dec_write = 1'b1;
                    dec_slot  = vsra_pkg::SLOT_W'(level_reg);
                    dec_level = level_reg + 1'b1;
                end
            end
            vsra_pkg::CMD_RESERVE:
            begin
                if (count_in == '0)
                begin
                    dec_status = vsra_pkg::ST_ZERO;
                end
                else if (level_reg > lim || count_in > lim - level_reg)
                begin
                    dec_status = vsra_pkg::ST_OVER;
                end
                else
                begin
                    dec_slot  = vsra_pkg::SLOT_W'(level_reg);
                    dec_level = level_reg + count_in;
                end
            end
            vsra_pkg::CMD_POP:
            begin
                if (level_reg == '0)
                begin
                    dec_status = vsra_pkg::ST_UNDER;
                end
                else
                begin
                    dec_read  = 1'b1;
                    dec_raddr = level_reg - 1'b1;
                    dec_level = level_reg - 1'b1;
                end
            end
            vsra_pkg::CMD_POP_MANY:
            begin
                if (count_in == '0)
                begin
                    dec_status = vsra_pkg::ST_ZERO;
                end
                else if (count_in > level_reg)
                begin
                    dec_status = vsra_pkg::ST_UNDER;
                end
                else
                begin
                    dec_read  = 1'b1;
                    dec_raddr = from_end_in ? (level_reg - 1'b1) : (level_reg - count_in);
                    dec_level = level_reg - count_in;
                end
            end
            vsra_pkg::CMD_REMOVE:
            begin
                if (count_in == '0)
                begin
                    dec_status = vsra_pkg::ST_ZERO;
                end
                else if (count_in > level_reg)
                begin
                    dec_status = vsra_pkg::ST_UNDER;
                end
                else
                begin
                    dec_read  = 1'b1;
                    dec_rem   = 1'b1;
                    dec_raddr = level_reg - count_in;
                    dec_level = level_reg - 1'b1;
                end
            end
            vsra_pkg::CMD_CLEAR:
            begin
                dec_level = '0;
            end
            default:
            begin
                dec_level = level_reg;
            end
        endcase
    end

    // sequencer and ram port control
    always_comb
    begin
        state_next   = state_reg;
        level_next   = level_reg;
        status_next  = status_reg;
        slot_next    = slot_reg;
        rd_next      = rd_reg;
        rem_next     = rem_reg;
        ptr_next     = ptr_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        ram_we       = 1'b0;
        ram_waddr    = vsra_pkg::ADDR_W'(level_reg);
        ram_wdata    = value_in;
        ram_raddr    = vsra_pkg::ADDR_W'(dec_raddr);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ram_we      = dec_write;
                    level_next  = dec_level;
                    status_next = dec_status;
                    slot_next   = dec_slot;
                    rd_next     = '0;
                    rem_next    = dec_rem;
                    ptr_next    = vsra_pkg::ADDR_W'(dec_raddr);
                    last_next   = vsra_pkg::ADDR_W'(level_reg - 1'b1);
                    state_next  = dec_read ? S_READ : S_DONE;
                end
            end
            S_READ:
            begin
                // capture the popped or removed value; for a remove, start the shift
                rd_next   = ram_rdata;
                ram_raddr = vsra_pkg::ADDR_W'(ptr_reg + 1'b1);
                if (rem_reg && ptr_reg < last_reg)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                // move the element above down by one slot
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                ram_raddr = vsra_pkg::ADDR_W'(ptr_reg + 2'd2);
                if (vsra_pkg::ADDR_W'(ptr_reg + 1'b1) < last_reg)
                begin
                    ptr_next = vsra_pkg::ADDR_W'(ptr_reg + 1'b1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {vsra_pkg::M_PAD_W'(0), level_reg, slot_reg,
                                    vsra_pkg::DATA_W'(rd_reg)};
                    m_user_next  = status_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            level_reg    <= '0;
            capacity_reg <= vsra_pkg::CAP_RESET;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        slot_reg   <= slot_next;
        rd_reg     <= rd_next;
        rem_reg    <= rem_next;
        ptr_reg    <= ptr_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // value store
    vsra_ram #(
        .WIDTH (vsra_pkg::VALUE_W),
        .DEPTH (vsra_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* src/vsra_ram.sv */
// ----------------------------------------------------------------------------
// vsra_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vsra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/vsra_checker.sv */
// ----------------------------------------------------------------------------
// vsra_checker
// port-level checks for the value stack core, bound to the top level
// ----------------------------------------------------------------------------
`include "value_stack_with_remove_at_core_assert.svh"

module vsra_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [vsra_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic [vsra_pkg::ST_W-1:0]          m_tuser
);

    // a stalled result holds
    `VSRA_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // the sequencer is busy in the cycle after each accepted request
    `VSRA_ASSERT_NXT(a_busy_after_req, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // reported level never exceeds the store and padding stays zero
    `VSRA_ASSERT_IMP(a_level_bound, clk, rst_n, m_tvalid,
        m_tdata[80:72] <= 9'd256 && m_tdata[87:81] == 7'd0)

    // a failed command returns no value and no slot
    `VSRA_ASSERT_IMP(a_fail_zero, clk, rst_n, m_tvalid && m_tuser != vsra_pkg::ST_OK,
        m_tdata[71:0] == 72'd0)

endmodule

bind value_stack_with_remove_at_core vsra_checker u_vsra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/value_stack_with_remove_at_core_test.sv */
// ----------------------------------------------------------------------------
// value_stack_with_remove_at_core_test
// self-checking bench for the bounded value stack core: requests are queued
// by a stimulus process, driven by a clocked driver, predicted on acceptance
// against a local stack model and compared field by field with each result
// ----------------------------------------------------------------------------
module value_stack_with_remove_at_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vsra_pkg::*;

    // spare command codes that the core must ignore
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // copies of the stack state: one tracks the planned stream, one checks
    localparam int PLAN_SIDE  = 0;
    localparam int CHECK_SIDE = 1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
        logic              from_end;
    } stack_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [ST_W-1:0]   status;
        logic [SLOT_W-1:0] slot_index;
        logic [LVL_W-1:0]  level;
    } stack_rsp_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [LVL_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;  // value, count, from_end, pad
    logic [CMD_W-1:0]     s_tuser   = '0;  // cmd
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // read_value, slot_index, level, pad
    logic [ST_W-1:0]      m_tuser;         // status

    // stack copies
    logic [VALUE_W-1:0] stack_mem [2][DEPTH];
    bit                 slot_written [2][DEPTH];
    int                 stack_depth [2];
    int                 stack_cap [2];

    stack_req_t pending_reqs [$];
    stack_rsp_t expected_rsps [$];
    stack_req_t live_req;
    stack_rsp_t got_rsp;
    stack_rsp_t want_rsp;
    int         issued_count   = 0;
    int         accepted_count = 0;
    int         results_seen   = 0;
    int         fail_count     = 0;
    bit         steady         = 1'b0;
    bit         offer;
    int         stall_left     = 0;
    bit         stall_done     = 1'b0;

    value_stack_with_remove_at_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // apply one command to a stack copy and return the result it gives
    function automatic stack_rsp_t apply_command(input int side, input stack_req_t r);
        stack_rsp_t rsp;
        int         lim;
        int         lvl;
        int         cnt;
        rsp.read_value = '0;
        rsp.status     = ST_OK;
        rsp.slot_index = '0;
        lim = (stack_cap[side] > DEPTH) ? DEPTH : stack_cap[side];
        lvl = stack_depth[side];
        cnt = int'(r.count);
        case (r.cmd)
            CMD_PUSH:
            begin
                if (lvl >= lim)
                    rsp.status = ST_OVER;
                else
                begin
                    stack_mem[side][lvl]    = r.value;
                    slot_written[side][lvl] = 1'b1;
                    rsp.slot_index          = SLOT_W'(lvl);
                    lvl                     = lvl + 1;
                end
            end
            CMD_RESERVE:
            begin
                if (cnt == 0)
                    rsp.status = ST_ZERO;
                else if (lvl > lim || cnt > lim - lvl)
                    rsp.status = ST_OVER;
                else
                begin
                    rsp.slot_index = SLOT_W'(lvl);
                    lvl            = lvl + cnt;
                end
            end
            CMD_POP:
            begin
                if (lvl == 0)
                    rsp.status = ST_UNDER;
                else
                begin
                    rsp.read_value = stack_mem[side][lvl-1];
                    lvl            = lvl - 1;
                end
            end
            CMD_POP_MANY:
            begin
                if (cnt == 0)
                    rsp.status = ST_ZERO;
                else if (cnt > lvl)
                    rsp.status = ST_UNDER;
                else
                begin
                    rsp.read_value = r.from_end ? stack_mem[side][lvl-1]
                                                : stack_mem[side][lvl-cnt];
                    lvl            = lvl - cnt;
                end
            end
            CMD_REMOVE:
            begin
                if (cnt == 0)
                    rsp.status = ST_ZERO;
                else if (cnt > lvl)
                    rsp.status = ST_UNDER;
                else
                begin
                    rsp.read_value = stack_mem[side][lvl-cnt];
                    // close the gap left by the removed element
                    for (int i = lvl - cnt; i + 1 < lvl; i++)
                    begin
                        stack_mem[side][i]    = stack_mem[side][i+1];
                        slot_written[side][i] = slot_written[side][i+1];
                    end
                    lvl = lvl - 1;
                end
            end
            CMD_CLEAR:
                lvl = 0;
            default:
                ;
        endcase
        stack_depth[side] = lvl;
        rsp.level         = LVL_W'(lvl);
        return rsp;
    endfunction

    // true when a command would read a slot never written since reset
    function automatic bit reads_blank(input stack_req_t r);
        int lvl;
        int cnt;
        lvl = stack_depth[PLAN_SIDE];
        cnt = int'(r.count);
        if (r.cmd == CMD_POP)
            return lvl > 0 && !slot_written[PLAN_SIDE][lvl-1];
        if (r.cmd != CMD_POP_MANY && r.cmd != CMD_REMOVE)
            return 1'b0;
        if (cnt == 0 || cnt > lvl)
            return 1'b0;
        if (r.cmd == CMD_POP_MANY)
            return !slot_written[PLAN_SIDE][r.from_end ? lvl - 1 : lvl - cnt];
        for (int i = lvl - cnt; i < lvl; i++)
            if (!slot_written[PLAN_SIDE][i])
                return 1'b1;
        return 1'b0;
    endfunction

    // random command, biased towards counts around the current level
    function automatic stack_req_t random_command();
        stack_req_t r;
        int         roll;
        int         lvl;
        lvl        = stack_depth[PLAN_SIDE];
        roll       = $urandom_range(0, 99);
        r.value    = {$urandom, $urandom};
        r.from_end = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0)
            r.count = CNT_W'($urandom);
        else
            r.count = CNT_W'($urandom_range(0, lvl + 2));
        if (roll < 34 || roll >= 92)
            r.cmd = CMD_PUSH;
        else if (roll < 44)
        begin
            r.cmd = CMD_RESERVE;
            if ($urandom_range(0, 3) != 0)
                r.count = CNT_W'($urandom_range(0, 3));
        end
        else if (roll < 58)
            r.cmd = CMD_POP;
        else if (roll < 70)
            r.cmd = CMD_POP_MANY;
        else if (roll < 85)
            r.cmd = CMD_REMOVE;
        else if (roll < 89)
            r.cmd = CMD_CLEAR;
        else
            r.cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        return r;
    endfunction

    task automatic queue_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                                 input int count, input bit from_end);
        stack_req_t r;
        r.cmd      = cmd;
        r.value    = value;
        r.count    = CNT_W'(count);
        r.from_end = from_end;
        void'(apply_command(PLAN_SIDE, r));
        pending_reqs.push_back(r);
        issued_count++;
    endtask

    task automatic queue_random(input int n);
        stack_req_t r;
        repeat (n)
        begin
            r = random_command();
            // keep reads inside slots that hold a defined value
            if (reads_blank(r))
                r.cmd = CMD_PUSH;
            queue_command(r.cmd, r.value, int'(r.count), r.from_end);
        end
    endtask

    task automatic wait_idle();
        while (accepted_count != issued_count || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input int cap);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= LVL_W'(cap);
        stack_cap[PLAN_SIDE]  = cap;
        stack_cap[CHECK_SIDE] = cap;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            offer = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                expected_rsps.push_back(apply_command(CHECK_SIDE, live_req));
                accepted_count++;
                offer = 1'b0;
            end
            if (!offer && pending_reqs.size() != 0
                && (steady || $urandom_range(0, 99) >= 30))
            begin
                live_req = pending_reqs.pop_front();
                offer    = 1'b1;
                s_tdata  <= {{(S_TDATA_W - DATA_W - CNT_W - 1){1'b0}},
                             live_req.from_end, live_req.count, live_req.value};
                s_tuser  <= live_req.cmd;
            end
            s_tvalid <= offer;
        end
    end

    // result acceptance, with one long hold-off once the fill is under way
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (!stall_done && results_seen >= 60)
            begin
                stall_left = 300;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= 30);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got_rsp.read_value = m_tdata[DATA_W-1:0];
            got_rsp.slot_index = m_tdata[DATA_W +: SLOT_W];
            got_rsp.level      = m_tdata[DATA_W + SLOT_W +: LVL_W];
            got_rsp.status     = m_tuser;
            if (expected_rsps.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                want_rsp = expected_rsps.pop_front();
                if (got_rsp.read_value !== want_rsp.read_value)
                begin
                    $error("read_value: expected %h, got %h",
                           want_rsp.read_value, got_rsp.read_value);
                    fail_count++;
                end
                if (got_rsp.status !== want_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", want_rsp.status, got_rsp.status);
                    fail_count++;
                end
                if (got_rsp.slot_index !== want_rsp.slot_index)
                begin
                    $error("slot_index: expected %0d, got %0d",
                           want_rsp.slot_index, got_rsp.slot_index);
                    fail_count++;
                end
                if (got_rsp.level !== want_rsp.level)
                begin
                    $error("level: expected %0d, got %0d", want_rsp.level, got_rsp.level);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("value_stack_with_remove_at_core_test failed");
        $finish;
    end

    // stimulus
    initial
    begin
        for (int s = 0; s < 2; s++)
        begin
            stack_depth[s] = 0;
            stack_cap[s]   = 256;
            for (int i = 0; i < DEPTH; i++)
            begin
                stack_mem[s][i]    = '0;
                slot_written[s][i] = 1'b0;
            end
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack errors and zero counts
        queue_command(CMD_POP, '0, 0, 1'b0);
        queue_command(CMD_POP_MANY, '0, 1, 1'b1);
        queue_command(CMD_REMOVE, '0, 1, 1'b0);
        queue_command(CMD_RESERVE, '0, 0, 1'b0);
        queue_command(CMD_POP_MANY, '0, 0, 1'b1);
        queue_command(CMD_REMOVE, '0, 0, 1'b0);
        // value extremes, then removal from the middle and both pop many picks
        queue_command(CMD_PUSH, '1, 0, 1'b0);
        queue_command(CMD_PUSH, '0, 0, 1'b0);
        queue_command(CMD_PUSH, {$urandom, $urandom}, 0, 1'b0);
        queue_command(CMD_PUSH, {$urandom, $urandom}, 0, 1'b1);
        queue_command(CMD_REMOVE, '0, 2, 1'b0);
        queue_command(CMD_POP_MANY, '0, 2, 1'b0);
        queue_command(CMD_POP_MANY, '0, 1, 1'b1);
        // spare codes are ignored
        queue_command(CMD_SPARE_LO, '1, 511, 1'b1);
        queue_command(CMD_SPARE_HI, '0, 0, 1'b0);
        // full stack by reserve, then overflow and oversized counts
        queue_command(CMD_RESERVE, '0, 256, 1'b0);
        queue_command(CMD_PUSH, '1, 0, 1'b0);
        queue_command(CMD_RESERVE, '0, 1, 1'b0);
        queue_command(CMD_POP_MANY, '0, 511, 1'b1);
        queue_command(CMD_REMOVE, '0, 257, 1'b0);
        queue_command(CMD_CLEAR, '0, 0, 1'b0);
        // reserved slots keep their earlier contents
        queue_command(CMD_RESERVE, '0, 3, 1'b0);
        queue_command(CMD_POP, '0, 0, 1'b0);
        queue_command(CMD_PUSH, {$urandom, $urandom}, 0, 1'b0);
        wait_idle();

        // capacity above the store size saturates; fill and remove the bottom
        write_capacity(511);
        queue_command(CMD_CLEAR, '0, 0, 1'b0);
        repeat (DEPTH)
            queue_command(CMD_PUSH, {$urandom, $urandom}, 0, 1'b0);
        queue_command(CMD_PUSH, '1, 0, 1'b0);
        queue_command(CMD_RESERVE, '0, 1, 1'b0);
        queue_command(CMD_REMOVE, '0, 256, 1'b0);
        queue_command(CMD_POP_MANY, '0, 2, 1'b1);
        wait_idle();

        // capacity below the current level
        write_capacity(3);
        queue_random(20);
        wait_idle();

        write_capacity(0);
        queue_random(10);
        wait_idle();

        write_capacity(1);
        queue_random(15);
        wait_idle();

        // back-to-back traffic on both sides
        steady = 1'b1;
        write_capacity(256);
        queue_random(50);
        wait_idle();
        steady = 1'b0;

        write_capacity($urandom_range(2, 511));
        queue_random(20);
        wait_idle();

        // let any stray result show up
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("value_stack_with_remove_at_core_test passed");
        else
            $display("value_stack_with_remove_at_core_test failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/vsra_pkg.sv
src/vsra_ram.sv
src/value_stack_with_remove_at_core.sv
src/vsra_checker.sv
tb/value_stack_with_remove_at_core_test.sv
